// ===== src/trd_pkg.sv =====
// Shared types and constants for the TLS record deframer.
`timescale 1ns / 1ps

package trd_pkg;

    localparam int HEADER_BYTES = 5;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [7:0] APP_DATA_TYPE = 8'h17;

    localparam logic [2:0] STEP_TYPE     = 3'd0;
    localparam logic [2:0] STEP_FIRST    = 3'd1;
    localparam logic [2:0] STEP_LEN_HI   = 3'(HEADER_BYTES - 2);
    localparam logic [2:0] STEP_LEN_LO   = 3'(HEADER_BYTES - 1);
    localparam logic [2:0] STEP_LIMIT    = 3'(HEADER_BYTES);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } trd_entry_t;

    typedef struct packed {
        logic       valid;
        trd_entry_t entry;
    } trd_push_t;

endpackage

// ===== src/trd_front.sv =====
// Header parser: tracks record framing and classifies each accepted byte.
`timescale 1ns / 1ps

module trd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    output trd_pkg::trd_push_t push
);
    import trd_pkg::*;

    logic [2:0]  step_reg, step_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] remain_reg, remain_next;
    logic        stopped_reg, stopped_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= STEP_TYPE;
            len_hi_reg  <= 8'd0;
            remain_reg  <= 16'd0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            len_hi_reg  <= len_hi_next;
            remain_reg  <= remain_next;
            stopped_reg <= stopped_next;
        end
    end

    always_comb
    begin
        step_next    = step_reg;
        len_hi_next  = len_hi_reg;
        remain_next  = remain_reg;
        stopped_next = stopped_reg;
        push         = '0;
        if (accept && !stopped_reg)
        begin
            if (remain_reg != 16'd0)
            begin
                remain_next      = remain_reg - 16'd1;
                push.valid       = 1'b1;
                push.entry.data  = in_byte;
                push.entry.last  = (remain_reg == 16'd1);
            end
            else if (step_reg == STEP_TYPE || step_reg >= STEP_LIMIT)
            begin
                if (in_byte != APP_DATA_TYPE)
                begin
                    stopped_next    = 1'b1;
                    step_next       = STEP_TYPE;
                    push.valid      = 1'b1;
                    push.entry.bad  = 1'b1;
                end
                else
                begin
                    step_next = STEP_FIRST;
                end
            end
            else if (step_reg == STEP_LEN_HI)
            begin
                len_hi_next = in_byte;
                step_next   = step_reg + 3'd1;
            end
            else if (step_reg == STEP_LEN_LO)
            begin
                remain_next = {len_hi_reg, in_byte};
                step_next   = STEP_TYPE;
            end
            else
            begin
                step_next = step_reg + 3'd1;
            end
        end
    end

    // once stopped, only reset restarts the parser
    a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stop flag cleared without reset");

    a_no_push_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> !push.valid)
        else $error("request produced while stopped");

endmodule

// ===== src/trd_queue.sv =====
// Short request queue between the parser and the output stage.
`timescale 1ns / 1ps

module trd_queue #(
    parameter int DEPTH = trd_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  trd_pkg::trd_push_t  push,
    input  logic                pop,
    output logic                not_empty,
    output logic                full,
    output trd_pkg::trd_entry_t head
);
    import trd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    trd_entry_t     slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign do_push   = push.valid;
    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_FULL);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push.entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (!full || pop))
        else $error("push into full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

endmodule

// ===== src/trd_back.sv =====
// Output stage: drains the queue into the result register.
`timescale 1ns / 1ps

module trd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  trd_pkg::trd_entry_t q_head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          payload_byte,
    output logic                last_in_record,
    output logic                bad_type
);
    import trd_pkg::*;

    logic       valid_reg;
    trd_entry_t data_reg;

    assign pop            = q_not_empty && (!valid_reg || !out_stall);
    assign out_valid      = valid_reg;
    assign payload_byte   = data_reg.data;
    assign last_in_record = data_reg.last;
    assign bad_type       = data_reg.bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= q_head;
    end

endmodule

// ===== src/tls_record_deframer_unit.sv =====
// Top level of the TLS record deframer.
`timescale 1ns / 1ps

// Accepts one record-stream byte per clock while in_stall is low and returns each
// payload byte, with last_in_record on the final byte of its record, on the output
// after it has been registered in a queue slot and then in the output register;
// header bytes and zero-length records give nothing. A header whose content type
// is not 0x17 gives one request with bad_type set, after which all input is
// consumed silently until reset. A QUEUE_DEPTH-entry queue sits between the header
// parser and the output register; in_stall rises only when that queue is full.
module tls_record_deframer_unit #(
    parameter int QUEUE_DEPTH = trd_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] payload_byte,
    output logic       last_in_record,
    output logic       bad_type
);
    import trd_pkg::*;

    trd_push_t  push;
    trd_entry_t q_head;
    logic       q_not_empty;
    logic       q_full;
    logic       pop;
    logic       accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    trd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .push    (push)
    );

    trd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head      (q_head)
    );

    trd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_byte   (payload_byte),
        .last_in_record (last_in_record),
        .bad_type       (bad_type)
    );

endmodule
